>>> hdl/mdcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdcl_pkg: shared types and constants of the mask dilation cell list
// Field widths, register and kind codes, the front-to-back work request and
// the result record.
// ----------------------------------------------------------------------------
package mdcl_pkg;

  localparam int unsigned MAX_LINE_DEF = 1024;  // default line store depth
  localparam int unsigned FRAME_MAX    = 1024;  // largest usable line length / count
  localparam int unsigned REG_W        = 11;
  localparam int unsigned LINE_W       = 10;
  localparam int unsigned POS_W        = 10;
  localparam int unsigned TOTAL_W      = 21;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned OUT_DEPTH    = 4;     // power of two
  localparam int unsigned OUT_AW       = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W    = $clog2(OUT_DEPTH + 1);

  typedef logic [REG_W-1:0]     reg_val_t;
  typedef logic [LINE_W-1:0]    line_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [TOTAL_W-1:0]   total_t;
  typedef logic [OUT_AW-1:0]    out_ptr_t;
  typedef logic [OUT_CNT_W-1:0] out_cnt_t;

  typedef enum logic {
    REG_LINE_LENGTH = 1'b0,
    REG_LINE_COUNT  = 1'b1
  } reg_idx_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_e;

  // One classified request handed from the front to the back.
  typedef struct packed {
    logic       lit;       // pixel value entering the window
    pos_t       pos;       // line store address
    logic       row_ok;    // decided cell lies inside the frame
    logic [2:0] rows;      // rows of the window inside the frame
    logic       left_ok;
    logic       right_ok;
    line_t      cell_row;
    pos_t       cell_col;
    logic       done;      // last drain request of the frame
  } work_t;

  typedef struct packed {
    line_t  cell_line;
    pos_t   cell_pos;
    logic   frame_done;
    total_t occupied_total;
  } result_t;

endpackage

>>> hdl/mask_dilate_cell_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_dilate_cell_list: streaming 3x3 dilation with a list of set cells
// Dilates a binary mask streamed in scan order and lists every set cell,
// closing each frame with a done result that carries the set cell count.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  cfg     | in        | cfg_we_i               | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i / in_stall_o | in_kind_i, in_lit_i
//  out     | out       | out_valid_o / out_stall_i | cell_line, cell_pos,
//          |           |                        | frame_done, occupied_total
//
// One request per cycle is taken while the queue is not full; the line store has
// one read and one write per request, which sets that rate. A result is held in
// the queue, the decide stage and then the result buffer before it is offered.
// A request that yields both a cell and the done result puts two results in the
// buffer, so a stalled output backs up the buffer, then the queue, then in_stall_o.
// Reset clears control state only; unwritten line store entries are never seen,
// because rows outside the frame are masked, so no clearing pass is run.
// Flush requests at the start of a frame are dropped in the front.
//
module mask_dilate_cell_list #(
  parameter int unsigned MAX_LINE = mdcl_pkg::MAX_LINE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [mdcl_pkg::REG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          in_kind_i,
  input  logic                          in_lit_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mdcl_pkg::LINE_W-1:0]   out_cell_line_o,
  output logic [mdcl_pkg::POS_W-1:0]    out_cell_pos_o,
  output logic                          out_frame_done_o,
  output logic [mdcl_pkg::TOTAL_W-1:0]  out_occupied_total_o
);

  mdcl_pkg::work_t   push_data, head;
  mdcl_pkg::result_t out_data;
  logic              push, q_full, q_valid, q_pop;

  // Front: hold configuration, track the scan position, classify requests.
  mdcl_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_kind_i    (in_kind_i),
    .in_lit_i     (in_lit_i),
    .queue_full_i (q_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  // Decouple intake from the decide stage.
  mdcl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  // Back: window, line store, count and result buffer.
  mdcl_back #(
    .MAX_LINE (MAX_LINE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .q_valid_i   (q_valid),
    .q_head_i    (head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  // Stall on a full queue only, never on in_valid_i.
  assign in_stall_o           = q_full;
  assign out_cell_line_o      = out_data.cell_line;
  assign out_cell_pos_o       = out_data.cell_pos;
  assign out_frame_done_o     = out_data.frame_done;
  assign out_occupied_total_o = out_data.occupied_total;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_frame_done_o |-> out_cell_line_o == '0 && out_cell_pos_o == '0)
    else $error("mask_dilate_cell_list: done result carries a cell position");
`endif

endmodule

>>> hdl/mdcl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdcl_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mdcl_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/mdcl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdcl_queue: work request queue between front and back
// Short register FIFO of classified requests.
// ----------------------------------------------------------------------------
module mdcl_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mdcl_pkg::work_t     push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output mdcl_pkg::work_t     head_o
);

  localparam int unsigned AW = $clog2(mdcl_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(mdcl_pkg::QUEUE_DEPTH + 1);

  mdcl_pkg::work_t slot_q [mdcl_pkg::QUEUE_DEPTH];
  logic [AW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CW'(mdcl_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wp_d    = wp_q;
    rp_d    = rp_q;
    count_d = count_q;
    if (do_push) begin
      wp_d = (wp_q == AW'(mdcl_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_q + AW'(1);
    end
    if (do_pop) begin
      rp_d = (rp_q == AW'(mdcl_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("mdcl_queue: request pushed while full");
`endif

endmodule

>>> hdl/mdcl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdcl_front: request intake and classification
// Holds the configuration, tracks the scan position and turns each request
// into a work request that names the window cell it decides.
// ----------------------------------------------------------------------------
module mdcl_front #(
  parameter int unsigned MAX_LINE = mdcl_pkg::MAX_LINE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  mdcl_pkg::reg_val_t    cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_kind_i,
  input  logic                  in_lit_i,
  input  logic                  queue_full_i,
  output logic                  push_o,
  output mdcl_pkg::work_t       push_data_o
);

  localparam int unsigned LEN_CAP =
    (MAX_LINE < mdcl_pkg::FRAME_MAX) ? MAX_LINE : mdcl_pkg::FRAME_MAX;
  localparam int unsigned PW = $clog2(LEN_CAP);
  localparam int unsigned RW = mdcl_pkg::REG_W;

  typedef logic [PW-1:0] idx_t;

  mdcl_pkg::reg_val_t len_q, cnt_q;
  mdcl_pkg::reg_val_t len_eff, cnt_eff;
  idx_t               pos_q, pos_d;
  mdcl_pkg::reg_val_t line_q, line_d;
  mdcl_pkg::reg_val_t off, rr, pos_inc;
  logic               accept, draining, pos_zero, drop, done;

  // Clamp the registers to their usable range.
  always_comb begin
    len_eff = len_q;
    if (len_q == '0) begin
      len_eff = RW'(1);
    end else if (len_q > RW'(LEN_CAP)) begin
      len_eff = RW'(LEN_CAP);
    end
    cnt_eff = cnt_q;
    if (cnt_q == '0) begin
      cnt_eff = RW'(1);
    end else if (cnt_q > RW'(mdcl_pkg::FRAME_MAX)) begin
      cnt_eff = RW'(mdcl_pkg::FRAME_MAX);
    end
  end

  assign accept   = in_valid_i && !queue_full_i;
  assign draining = (line_q >= cnt_eff);
  assign pos_zero = (pos_q == '0);
  assign drop     = !draining && (in_kind_i == mdcl_pkg::KIND_FLUSH)
                    && (line_q == '0) && pos_zero;
  assign done     = (line_q >= cnt_eff + RW'(1));
  assign off      = pos_zero ? RW'(2) : RW'(1);
  assign rr       = line_q - off;
  assign pos_inc  = RW'(pos_q) + RW'(1);

  always_comb begin
    push_data_o          = '0;
    push_data_o.lit      = !draining && (in_kind_i == mdcl_pkg::KIND_PIXEL) && in_lit_i;
    push_data_o.pos      = mdcl_pkg::pos_t'(pos_q);
    push_data_o.row_ok   = (line_q >= off) && (rr < cnt_eff);
    push_data_o.rows[2]  = (line_q >= off + RW'(1));
    push_data_o.rows[1]  = 1'b1;
    push_data_o.rows[0]  = (rr + RW'(1) < cnt_eff);
    push_data_o.left_ok  = pos_zero ? (len_eff >= RW'(2)) : (pos_q >= PW'(2));
    push_data_o.right_ok = !pos_zero;
    push_data_o.cell_row = rr[mdcl_pkg::LINE_W-1:0];
    push_data_o.cell_col = pos_zero ? mdcl_pkg::pos_t'(len_eff - RW'(1))
                                    : mdcl_pkg::pos_t'(pos_q - PW'(1));
    push_data_o.done     = done;
  end

  assign push_o = accept && !drop;

  // Advance the scan position; return to the frame start after done or on a register write.
  always_comb begin
    pos_d  = pos_q;
    line_d = line_q;
    if (cfg_we_i) begin
      pos_d  = '0;
      line_d = '0;
    end else if (push_o) begin
      if (done) begin
        pos_d  = '0;
        line_d = '0;
      end else if (pos_inc >= len_eff) begin
        pos_d  = '0;
        line_d = line_q + RW'(1);
      end else begin
        pos_d  = pos_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= RW'(1);
      cnt_q  <= RW'(1);
      pos_q  <= '0;
      line_q <= '0;
    end else begin
      if (cfg_we_i && (cfg_index_i == mdcl_pkg::REG_LINE_LENGTH)) begin
        len_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == mdcl_pkg::REG_LINE_COUNT)) begin
        cnt_q <= cfg_data_i;
      end
      pos_q  <= pos_d;
      line_q <= line_d;
    end
  end

endmodule

>>> hdl/mdcl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdcl_back: window, line store and result buffer
// Reads the line store, shifts the 3x3 window, decides one cell per request
// and queues up to two results per request in an output buffer.
// ----------------------------------------------------------------------------
module mdcl_back #(
  parameter int unsigned MAX_LINE = mdcl_pkg::MAX_LINE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 q_valid_i,
  input  mdcl_pkg::work_t      q_head_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mdcl_pkg::result_t    out_data_o
);

  localparam int unsigned LEN_CAP =
    (MAX_LINE < mdcl_pkg::FRAME_MAX) ? MAX_LINE : mdcl_pkg::FRAME_MAX;
  localparam int unsigned AW = $clog2(LEN_CAP);
  localparam int unsigned TW = mdcl_pkg::TOTAL_W;

  mdcl_pkg::work_t    b_q;
  logic               b_valid_q;
  logic               fwd_q;
  logic [1:0]         fwd_data_q;
  logic [5:0]         window_q;
  mdcl_pkg::total_t   occ_q;
  logic [1:0]         ram_rdata, prev;
  logic [2:0]         vec, any;
  logic               adv, pop, cell_emit;
  mdcl_pkg::total_t   occ_next;
  mdcl_pkg::result_t  cell_res, done_res;

  mdcl_pkg::result_t  buf_q [mdcl_pkg::OUT_DEPTH];
  mdcl_pkg::out_ptr_t wp_q, rp_q;
  mdcl_pkg::out_cnt_t ocnt_q, ocnt_d;
  logic               out_pop;
  logic [1:0]         n_res;

  mdcl_ram #(
    .WIDTH (2),
    .DEPTH (LEN_CAP)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (adv),
    .waddr_i (b_q.pos[AW-1:0]),
    .wdata_i (vec[1:0]),
    .re_i    (pop),
    .raddr_i (q_head_i.pos[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Advance the decide stage only with room for two results.
  assign adv = b_valid_q && (ocnt_q <= mdcl_pkg::out_cnt_t'(mdcl_pkg::OUT_DEPTH - 2));
  assign pop = q_valid_i && (!b_valid_q || adv);
  assign q_pop_o = pop;

  assign prev = fwd_q ? fwd_data_q : ram_rdata;
  assign vec  = {prev, b_q.lit};
  assign any  = (window_q[2:0]
                 | (b_q.left_ok  ? window_q[5:3] : 3'b000)
                 | (b_q.right_ok ? vec           : 3'b000)) & b_q.rows;
  assign cell_emit = b_q.row_ok && (any != 3'b000);
  assign occ_next  = occ_q + TW'(cell_emit);

  always_comb begin
    cell_res                = '0;
    cell_res.cell_line      = b_q.cell_row;
    cell_res.cell_pos       = b_q.cell_col;
    done_res                = '0;
    done_res.frame_done     = 1'b1;
    done_res.occupied_total = occ_next;
  end

  assign n_res   = adv ? (2'(cell_emit) + 2'(b_q.done)) : 2'd0;
  assign out_pop = out_valid_o && !out_stall_i;

  always_comb begin
    ocnt_d = ocnt_q + mdcl_pkg::out_cnt_t'(n_res);
    if (out_pop) begin
      ocnt_d = ocnt_d - mdcl_pkg::out_cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
      window_q  <= '0;
      occ_q     <= '0;
      wp_q      <= '0;
      rp_q      <= '0;
      ocnt_q    <= '0;
    end else begin
      if (pop) begin
        b_valid_q <= 1'b1;
        // Same address written this cycle: bypass the stale read.
        fwd_q     <= adv && (q_head_i.pos[AW-1:0] == b_q.pos[AW-1:0]);
      end else if (adv) begin
        b_valid_q <= 1'b0;
        fwd_q     <= 1'b0;
      end
      if (cfg_we_i) begin
        window_q <= '0;
        occ_q    <= '0;
      end else if (adv) begin
        if (b_q.done) begin
          window_q <= '0;
          occ_q    <= '0;
        end else begin
          window_q <= {window_q[2:0], vec};
          occ_q    <= occ_next;
        end
      end
      wp_q   <= wp_q + mdcl_pkg::out_ptr_t'(n_res);
      if (out_pop) begin
        rp_q <= rp_q + mdcl_pkg::out_ptr_t'(1);
      end
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      b_q        <= q_head_i;
      fwd_data_q <= vec[1:0];
    end
    if (n_res != 2'd0) begin
      buf_q[wp_q] <= cell_emit ? cell_res : done_res;
    end
    if (n_res == 2'd2) begin
      buf_q[wp_q + mdcl_pkg::out_ptr_t'(1)] <= done_res;
    end
  end

  assign out_valid_o = (ocnt_q != '0);
  assign out_data_o  = buf_q[rp_q];

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= mdcl_pkg::out_cnt_t'(mdcl_pkg::OUT_DEPTH))
    else $error("mdcl_back: result buffer overrun");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && b_q.done |=> occ_q == '0)
    else $error("mdcl_back: count not cleared after frame done");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> b_valid_q)
    else $error("mdcl_back: bypass flag without a request in the decide stage");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for mask_dilate_cell_list
// Streams binary mask frames through the dilation block under random sender
// bursts and receiver stalls, predicts every set cell and each frame's done
// record in scan order, and checks each result field by field on arrival.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_LIMIT  = 12;   // idle cycles before a register write
  localparam int unsigned TAIL_CYCLES   = 20;   // stray-result watch after the last result
  localparam int unsigned ITEM_TARGET   = 1300;
  localparam int unsigned BIG_ITEMS     = mdcl_pkg::FRAME_MAX + 2;  // full-height column
  localparam int unsigned RANDOM_TARGET = ITEM_TARGET - BIG_ITEMS;
  localparam int unsigned MAX_REPORTS   = 10;

  // One entry of the sender's list: either a mask request or a register write.
  typedef struct {
    bit                 is_cfg;
    mdcl_pkg::reg_idx_e idx;
    mdcl_pkg::reg_val_t data;
    mdcl_pkg::kind_e    kind;
    logic               lit;
  } request_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_index_i = 1'b0;
  mdcl_pkg::reg_val_t cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_kind_i = 1'b0;
  logic               in_lit_i = 1'b0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  mdcl_pkg::line_t    out_cell_line_o;
  mdcl_pkg::pos_t     out_cell_pos_o;
  logic               out_frame_done_o;
  mdcl_pkg::total_t   out_occupied_total_o;

  mask_dilate_cell_list i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .in_kind_i            (in_kind_i),
    .in_lit_i             (in_lit_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_cell_line_o      (out_cell_line_o),
    .out_cell_pos_o       (out_cell_pos_o),
    .out_frame_done_o     (out_frame_done_o),
    .out_occupied_total_o (out_occupied_total_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  request_t          pending[$];    // requests and register writes still to be sent
  mdcl_pkg::result_t cells_due[$];  // predicted results, oldest first
  int unsigned       stim_items;
  int unsigned       mismatch_count;
  int unsigned       cycle_count;
  int unsigned       quiet_cycles;
  int unsigned       reqs_taken;
  bit                req_fired;

  // --------------------------------------------------------------------------
  // Dilation predictor: own copy of registers, line history and window
  // --------------------------------------------------------------------------
  mdcl_pkg::reg_val_t len_reg = mdcl_pkg::reg_val_t'(1);
  mdcl_pkg::reg_val_t cnt_reg = mdcl_pkg::reg_val_t'(1);
  bit [1:0]           line_hist [mdcl_pkg::FRAME_MAX];  // line-2 in bit 1, line-1 in bit 0
  bit [5:0]           win_cols;                         // two previous columns, older on top
  int unsigned        next_line;
  int unsigned        next_pos;
  mdcl_pkg::total_t   occupied;

  function automatic int unsigned clamp_size(input mdcl_pkg::reg_val_t v);
    if (v == 0) return 1;
    if (v > mdcl_pkg::FRAME_MAX) return mdcl_pkg::FRAME_MAX;
    return 32'(v);
  endfunction

  function automatic void clear_frame();
    win_cols  = '0;
    next_line = 0;
    next_pos  = 0;
    occupied  = '0;
  endfunction

  function automatic void write_model_reg(input mdcl_pkg::reg_idx_e idx,
                                          input mdcl_pkg::reg_val_t value);
    if (idx == mdcl_pkg::REG_LINE_LENGTH) len_reg = value;
    else cnt_reg = value;
    clear_frame();
  endfunction

  task automatic predict_cells(input mdcl_pkg::kind_e kind, input logic lit);
    int unsigned       len, cnt, pos, line, cell_col;
    int                cell_row;
    bit                drain, px, left_ok, right_ok;
    bit [2:0]          col, left, center, right, rows, any;
    mdcl_pkg::result_t r;
    len   = clamp_size(len_reg);
    cnt   = clamp_size(cnt_reg);
    pos   = next_pos;
    line  = next_line;
    drain = (line >= cnt);
    px    = 1'b0;
    if (!drain) begin
      // drop a flush before the first pixel of a frame
      if (kind == mdcl_pkg::KIND_FLUSH && line == 0 && pos == 0) return;
      px = (kind == mdcl_pkg::KIND_PIXEL) ? lit : 1'b0;
    end
    col = {line_hist[pos], px};
    line_hist[pos] = col[1:0];
    left   = win_cols[5:3];
    center = win_cols[2:0];
    if (pos >= 1) begin
      cell_row = int'(line) - 1;
      cell_col = pos - 1;
      right    = col;
      left_ok  = (pos >= 2);
      right_ok = 1'b1;
    end else begin
      // first position of a line closes the last cell of the line before
      cell_row = int'(line) - 2;
      cell_col = len - 1;
      right    = '0;
      left_ok  = (len >= 2);
      right_ok = 1'b0;
    end
    if (cell_row >= 0 && cell_row < int'(cnt)) begin
      rows = 3'b010;
      if (cell_row >= 1) rows[2] = 1'b1;
      if (cell_row + 1 < int'(cnt)) rows[0] = 1'b1;
      any = center;
      if (left_ok) any |= left;
      if (right_ok) any |= right;
      any &= rows;
      if (any != 0) begin
        occupied = occupied + mdcl_pkg::total_t'(1);
        r.cell_line      = mdcl_pkg::line_t'(cell_row);
        r.cell_pos       = mdcl_pkg::pos_t'(cell_col);
        r.frame_done     = 1'b0;
        r.occupied_total = '0;
        cells_due.insert(cells_due.size(), r);
      end
    end
    if (drain && line >= cnt + 1) begin
      r.cell_line      = '0;
      r.cell_pos       = '0;
      r.frame_done     = 1'b1;
      r.occupied_total = occupied;
      cells_due.insert(cells_due.size(), r);
      clear_frame();
      return;
    end
    win_cols = {win_cols[2:0], col};
    pos++;
    if (pos >= len) begin
      pos = 0;
      line++;
    end
    next_pos  = pos;
    next_line = line;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus list builders
  // --------------------------------------------------------------------------
  task automatic queue_cfg(input mdcl_pkg::reg_idx_e idx, input int unsigned value);
    request_t q;
    q.is_cfg = 1'b1;
    q.idx    = idx;
    q.data   = mdcl_pkg::reg_val_t'(value);
    q.kind   = mdcl_pkg::KIND_FLUSH;
    q.lit    = 1'b0;
    pending.insert(pending.size(), q);
  endtask

  // counted is low for requests that the block drops at frame start
  task automatic queue_item(input mdcl_pkg::kind_e kind, input logic lit, input bit counted);
    request_t q;
    q.is_cfg = 1'b0;
    q.idx    = mdcl_pkg::REG_LINE_LENGTH;
    q.data   = '0;
    q.kind   = kind;
    q.lit    = lit;
    pending.insert(pending.size(), q);
    if (counted) stim_items++;
  endtask

  // One frame in scan order followed by its drain. A rough frame carries
  // leading flushes, holes punched by flushes and pixels mixed into the drain.
  // A frame is cut short after cut requests.
  task automatic queue_frame(input int unsigned len, input int unsigned cnt,
                             input int unsigned density, input bit rough,
                             input int unsigned cut);
    int unsigned n;
    if (rough) begin
      repeat ($urandom_range(0, 2)) queue_item(mdcl_pkg::KIND_FLUSH, 1'($urandom), 1'b0);
    end
    for (n = 0; n < len * cnt + len + 1 && n < cut; n++) begin
      if (n < len * cnt) begin
        if (rough && n != 0 && $urandom_range(0, 15) == 0) begin
          queue_item(mdcl_pkg::KIND_FLUSH, 1'($urandom), 1'b1);
        end else begin
          queue_item(mdcl_pkg::KIND_PIXEL, $urandom_range(0, 99) < density, 1'b1);
        end
      end else begin
        if (rough && $urandom_range(0, 2) == 0) begin
          queue_item(mdcl_pkg::KIND_PIXEL, 1'($urandom), 1'b1);
        end else begin
          queue_item(mdcl_pkg::KIND_FLUSH, 1'($urandom), 1'b1);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: bursts with random gaps; register writes only once the block is idle
  // --------------------------------------------------------------------------
  int unsigned        burst_left;
  int unsigned        gap_left;
  logic               nx_valid, nx_we, nx_kind, nx_lit, nx_idx;
  mdcl_pkg::reg_val_t nx_data;

  always @(negedge clk_i) begin
    // hold a request that has not yet been taken
    if (rst_ni && !(in_valid_i && !req_fired)) begin
      nx_valid = 1'b0;
      nx_we    = 1'b0;
      nx_kind  = in_kind_i;
      nx_lit   = in_lit_i;
      nx_idx   = cfg_index_i;
      nx_data  = cfg_data_i;
      if (pending.size() != 0) begin
        if (pending[0].is_cfg) begin
          // write only with nothing due and the pipeline given time to empty
          if (cells_due.size() == 0 && quiet_cycles >= SETTLE_LIMIT) begin
            nx_we   = 1'b1;
            nx_idx  = pending[0].idx;
            nx_data = pending[0].data;
            write_model_reg(pending[0].idx, pending[0].data);
            void'(pending.pop_front());
          end
        end else begin
          if (burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 64);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
          if (burst_left != 0) begin
            burst_left--;
            nx_valid = 1'b1;
            nx_kind  = pending[0].kind;
            nx_lit   = pending[0].lit;
          end else begin
            gap_left--;
          end
        end
      end
      in_valid_i  <= nx_valid;
      in_kind_i   <= nx_kind;
      in_lit_i    <= nx_lit;
      cfg_we_i    <= nx_we;
      cfg_index_i <= nx_idx;
      cfg_data_i  <= nx_data;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall pattern: calm, sparse, heavy and alternating stretches,
  // plus long hold-offs that back the block up into in_stall_o
  // --------------------------------------------------------------------------
  int unsigned stall_mode;
  int unsigned stretch_left;
  int unsigned hold_left;
  bit          held_once;
  logic        nx_stall;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left--;
        nx_stall = 1'b1;
      end else if (!held_once && reqs_taken >= 200) begin
        held_once = 1'b1;
        hold_left = 400;
        nx_stall  = 1'b1;
      end else if ($urandom_range(0, 1999) == 0) begin
        hold_left = $urandom_range(100, 300);
        nx_stall  = 1'b1;
      end else begin
        if (stretch_left == 0) begin
          stall_mode   = $urandom_range(0, 3);
          stretch_left = $urandom_range(20, 200);
        end
        stretch_left--;
        case (stall_mode)
          0:       nx_stall = 1'b0;
          1:       nx_stall = ($urandom_range(0, 3) == 0);
          2:       nx_stall = 1'($urandom);
          default: nx_stall = ~out_stall_i;
        endcase
      end
      out_stall_i <= nx_stall;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check results, then advance the predictor on accepted requests
  // --------------------------------------------------------------------------
  mdcl_pkg::result_t got_cell, want_cell;

  task automatic log_mismatch(input string what, input mdcl_pkg::result_t want,
                              input mdcl_pkg::result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] %s: expected line %0d pos %0d done %0b total %0d, %s %0d %s %0d %s %0b %s %0d",
               $time, what, want.cell_line, want.cell_pos, want.frame_done,
               want.occupied_total, "got line", got.cell_line, "pos", got.cell_pos,
               "done", got.frame_done, "total", got.occupied_total);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("[%0t] cycle limit reached with %0d results due", $time, cells_due.size());
        $display("end of test: mismatches");
        $finish;
      end else begin
        if (out_valid_o && !out_stall_i) begin
          got_cell.cell_line      = out_cell_line_o;
          got_cell.cell_pos       = out_cell_pos_o;
          got_cell.frame_done     = out_frame_done_o;
          got_cell.occupied_total = out_occupied_total_o;
          if (cells_due.size() == 0) begin
            log_mismatch("result with nothing due", '0, got_cell);
          end else begin
            want_cell = cells_due.pop_front();
            if (got_cell.cell_line !== want_cell.cell_line ||
                got_cell.cell_pos !== want_cell.cell_pos ||
                got_cell.frame_done !== want_cell.frame_done ||
                got_cell.occupied_total !== want_cell.occupied_total)
              log_mismatch("result differs", want_cell, got_cell);
          end
        end
        req_fired = in_valid_i && !in_stall_o;
        if (req_fired) begin
          predict_cells(mdcl_pkg::kind_e'(in_kind_i), in_lit_i);
          void'(pending.pop_front());
          quiet_cycles = 0;
          reqs_taken++;
        end else if (quiet_cycles < SETTLE_LIMIT) begin
          quiet_cycles++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed cases, random phases, then the largest frame height
  // --------------------------------------------------------------------------
  int unsigned sel, len, cnt, frames, density, cut, f;
  bit          rough;

  initial begin
    // reset sizes are one by one: a drop at frame start, one lit pixel,
    // a pixel standing in as drain, the closing flush, a flush beyond the drain
    queue_item(mdcl_pkg::KIND_FLUSH, 1'b1, 1'b0);
    queue_item(mdcl_pkg::KIND_PIXEL, 1'b1, 1'b1);
    queue_item(mdcl_pkg::KIND_PIXEL, 1'b1, 1'b1);
    queue_item(mdcl_pkg::KIND_FLUSH, 1'b0, 1'b1);
    queue_item(mdcl_pkg::KIND_FLUSH, 1'b0, 1'b0);
    // three by two with corner pixels, a hole and a mixed drain
    queue_cfg(mdcl_pkg::REG_LINE_COUNT, 2);
    queue_cfg(mdcl_pkg::REG_LINE_LENGTH, 3);
    queue_item(mdcl_pkg::KIND_PIXEL, 1'b1, 1'b1);
    queue_item(mdcl_pkg::KIND_PIXEL, 1'b0, 1'b1);
    queue_item(mdcl_pkg::KIND_PIXEL, 1'b0, 1'b1);
    queue_item(mdcl_pkg::KIND_FLUSH, 1'b1, 1'b1);
    queue_item(mdcl_pkg::KIND_PIXEL, 1'b0, 1'b1);
    queue_item(mdcl_pkg::KIND_PIXEL, 1'b1, 1'b1);
    queue_item(mdcl_pkg::KIND_PIXEL, 1'b1, 1'b1);
    queue_item(mdcl_pkg::KIND_FLUSH, 1'b0, 1'b1);
    queue_item(mdcl_pkg::KIND_PIXEL, 1'b0, 1'b1);
    queue_item(mdcl_pkg::KIND_FLUSH, 1'b0, 1'b1);
    // abort a frame part way through
    queue_cfg(mdcl_pkg::REG_LINE_LENGTH, 2);
    queue_item(mdcl_pkg::KIND_PIXEL, 1'b1, 1'b1);
    queue_item(mdcl_pkg::KIND_PIXEL, 1'b1, 1'b1);
    queue_item(mdcl_pkg::KIND_PIXEL, 1'b0, 1'b1);
    // zero sizes clamp to one: an empty frame closes with a zero count
    queue_cfg(mdcl_pkg::REG_LINE_LENGTH, 0);
    queue_cfg(mdcl_pkg::REG_LINE_COUNT, 0);
    queue_item(mdcl_pkg::KIND_PIXEL, 1'b0, 1'b1);
    queue_item(mdcl_pkg::KIND_FLUSH, 1'b0, 1'b1);
    queue_item(mdcl_pkg::KIND_FLUSH, 1'b0, 1'b1);

    // random phases, mostly small frames
    while (stim_items < RANDOM_TARGET) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        len = $urandom_range(1, 6);
        cnt = $urandom_range(1, 6);
      end else if (sel < 9) begin
        len = $urandom_range(7, 40);
        cnt = $urandom_range(1, 4);
      end else begin
        len = $urandom_range(1, 3);
        cnt = $urandom_range(20, 60);
      end
      if ($urandom_range(0, 1) == 0) begin
        queue_cfg(mdcl_pkg::REG_LINE_LENGTH,
                  (len == 1 && $urandom_range(0, 1) == 0) ? 0 : len);
        queue_cfg(mdcl_pkg::REG_LINE_COUNT, cnt);
      end else begin
        queue_cfg(mdcl_pkg::REG_LINE_COUNT,
                  (cnt == 1 && $urandom_range(0, 1) == 0) ? 0 : cnt);
        queue_cfg(mdcl_pkg::REG_LINE_LENGTH, len);
      end
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames && stim_items < RANDOM_TARGET; f++) begin
        case ($urandom_range(0, 4))
          0:       density = 0;
          1:       density = 5;
          2:       density = 30;
          3:       density = 70;
          default: density = 100;
        endcase
        rough = ($urandom_range(0, 3) == 0);
        cut   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, len * cnt + len) : '1;
        queue_frame(len, cnt, density, rough, cut);
      end
    end

    // largest height: a full single column with every count register bit set
    queue_cfg(mdcl_pkg::REG_LINE_COUNT, 2047);
    queue_cfg(mdcl_pkg::REG_LINE_LENGTH, 1);
    queue_frame(1, mdcl_pkg::FRAME_MAX, 20, 1'b0, '1);
    queue_cfg(mdcl_pkg::REG_LINE_COUNT, 1);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending.size() != 0 || cells_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    mismatch_count += cells_due.size();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/mdcl_pkg.sv
hdl/mdcl_ram.sv
hdl/mdcl_queue.sv
hdl/mdcl_front.sv
hdl/mdcl_back.sv
hdl/mask_dilate_cell_list.sv
tb/sv/testbench.sv
